### rtl/ax25_pkg.sv
// Shared types, constants and functions for the AX.25 UI frame builder.
package ax25_pkg;

	localparam logic [47:0] CALL_SPACES  = 48'h2020_2020_2020;
	localparam logic [7:0]  MAXPAY_RESET = 8'd150;
	localparam logic [7:0]  CTRL_UI      = 8'h03;
	localparam logic [7:0]  PID_NONE     = 8'hF0;
	localparam logic [7:0]  SSID_FIXED   = 8'h60;
	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [3:0]  HDR_LAST     = 4'd15;
	localparam int          QUEUE_DEPTH  = 4;

	typedef enum logic [2:0] {
		CFG_DEST_CALL = 3'd0,
		CFG_DEST_SSID = 3'd1,
		CFG_SRC_CALL  = 3'd2,
		CFG_SRC_SSID  = 3'd3,
		CFG_MAX_PAY   = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_DATA,
		PH_FCSL,
		PH_FCSH
	} phase_t;

	// Address fields for the header
	typedef struct packed {
		logic [47:0] dst_call;
		logic [3:0]  dest_ssid;
		logic [47:0] src_call;
		logic [3:0]  src_ssid;
	} addr_cfg_t;

	// One classified payload word waiting for the back end
	typedef struct packed {
		logic [7:0] data;
		logic       open;
		logic       close;
	} entry_t;

	function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) c = (c >> 1) ^ CRC_POLY;
			else      c = c >> 1;
		end
		return c;
	endfunction

	function automatic logic [7:0] ssid_byte(logic [3:0] ssid, logic endbit);
		return SSID_FIXED | {3'b000, ssid, endbit};
	endfunction

	// Header byte at position idx (0..15)
	function automatic logic [7:0] hdr_byte(logic [3:0] idx, addr_cfg_t c);
		logic [7:0] b;
		case (idx)
			4'd0:    b = {c.dst_call[46:40], 1'b0};
			4'd1:    b = {c.dst_call[38:32], 1'b0};
			4'd2:    b = {c.dst_call[30:24], 1'b0};
			4'd3:    b = {c.dst_call[22:16], 1'b0};
			4'd4:    b = {c.dst_call[14:8], 1'b0};
			4'd5:    b = {c.dst_call[6:0], 1'b0};
			4'd6:    b = ssid_byte(c.dest_ssid, 1'b0);
			4'd7:    b = {c.src_call[46:40], 1'b0};
			4'd8:    b = {c.src_call[38:32], 1'b0};
			4'd9:    b = {c.src_call[30:24], 1'b0};
			4'd10:   b = {c.src_call[22:16], 1'b0};
			4'd11:   b = {c.src_call[14:8], 1'b0};
			4'd12:   b = {c.src_call[6:0], 1'b0};
			4'd13:   b = ssid_byte(c.src_ssid, 1'b1);
			4'd14:   b = CTRL_UI;
			default: b = PID_NONE;
		endcase
		return b;
	endfunction

endpackage

### rtl/ax25_fe.sv
// Front end: accepts payload words and marks frame open and close.
module ax25_fe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_of_input,
	input  logic [7:0]          pay_limit,
	output logic                push,
	output ax25_pkg::entry_t    push_entry
);

	logic       in_frame_q;
	logic [7:0] count_q;
	logic [7:0] cnt_next;
	logic       close;

	assign push     = in_valid && !in_stall;
	assign cnt_next = (in_frame_q ? count_q : 8'd0) + 8'd1;
	assign close    = last_of_input || (cnt_next >= pay_limit);

	assign push_entry.data  = data_byte;
	assign push_entry.open  = !in_frame_q;
	assign push_entry.close = close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= 8'd0;
		end else if (push) begin
			in_frame_q <= !close;
			count_q    <= close ? 8'd0 : cnt_next;
		end
	end

endmodule

### rtl/ax25_q.sv
// Small queue of classified words between front and back end.
module ax25_q #(
	parameter int Depth = ax25_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ax25_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output ax25_pkg::entry_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	ax25_pkg::entry_t mem [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full       = (cnt_q == CntFull);
	assign head_valid = (cnt_q != '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### rtl/ax25_be.sv
// Back end: emits header, payload and FCS bytes and keeps the CRC.
module ax25_be (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  ax25_pkg::entry_t     head,
	input  ax25_pkg::addr_cfg_t  addr_cfg,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 frame_end,
	output logic                 run_end
);

	ax25_pkg::phase_t phase_q, phase_d;
	logic [3:0]  idx_q, idx_d;
	logic [15:0] crc_q, crc_d;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q, run_end_q;
	logic        adv, fire;
	logic [7:0]  byte_d;
	logic        fend_d, rend_d;
	logic [15:0] fcs;

	assign adv  = !out_valid_q || !out_stall;
	assign fire = adv && head_valid;
	assign fcs  = ~crc_q;

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		crc_d   = crc_q;
		byte_d  = head.data;
		fend_d  = 1'b0;
		rend_d  = 1'b0;
		pop     = 1'b0;
		case (phase_q)
			ax25_pkg::PH_IDLE, ax25_pkg::PH_DATA: begin
				if (phase_q == ax25_pkg::PH_IDLE && head.open) begin
					byte_d  = ax25_pkg::hdr_byte(4'd0, addr_cfg);
					crc_d   = ax25_pkg::crc_byte(crc_q, byte_d);
					idx_d   = 4'd1;
					phase_d = ax25_pkg::PH_HDR;
				end else begin
					byte_d = head.data;
					crc_d  = ax25_pkg::crc_byte(crc_q, byte_d);
					if (head.close) begin
						phase_d = ax25_pkg::PH_FCSL;
					end else begin
						phase_d = ax25_pkg::PH_IDLE;
						rend_d  = 1'b1;
						pop     = fire;
					end
				end
			end
			ax25_pkg::PH_HDR: begin
				byte_d = ax25_pkg::hdr_byte(idx_q, addr_cfg);
				crc_d  = ax25_pkg::crc_byte(crc_q, byte_d);
				idx_d  = idx_q + 4'd1;
				if (idx_q == ax25_pkg::HDR_LAST) phase_d = ax25_pkg::PH_DATA;
			end
			ax25_pkg::PH_FCSL: begin
				byte_d  = fcs[7:0];
				phase_d = ax25_pkg::PH_FCSH;
			end
			ax25_pkg::PH_FCSH: begin
				byte_d  = fcs[15:8];
				fend_d  = 1'b1;
				rend_d  = 1'b1;
				crc_d   = ax25_pkg::CRC_INIT;
				phase_d = ax25_pkg::PH_IDLE;
				pop     = fire;
			end
			default: begin
				phase_d = ax25_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ax25_pkg::PH_IDLE;
			idx_q       <= 4'd0;
			crc_q       <= ax25_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (fire) begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				crc_q   <= crc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q  <= byte_d;
			frame_end_q <= fend_d;
			run_end_q   <= rend_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_end   = run_end_q;

`ifndef SYNTHESIS
	a_fend_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_end_q)
		else $error("frame end without run end");
	a_mid_word_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != ax25_pkg::PH_IDLE |-> head_valid)
		else $error("back end mid word with empty queue");
	a_hdr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ax25_pkg::PH_HDR |-> idx_q != 4'd0)
		else $error("header index restarted inside header");
	a_crc_init_at_open: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == ax25_pkg::PH_IDLE && head.open |-> crc_q == ax25_pkg::CRC_INIT)
		else $error("frame opened with stale CRC");
`endif

endmodule

### rtl/ax25_ui_frame_builder_top.sv
// Top level of the AX.25 UI frame builder: config registers, front end, queue, back end.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | sink      | in_valid / in_stall   | data_byte, last_of_input
//  out     | source    | out_valid / out_stall | out_byte, frame_end, run_end
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// The back end emits one byte per cycle while out_stall is low and a word is queued, so
// a payload word in an open frame yields one byte; an opening word adds 16 header bytes
// and a closing word adds 2 FCS bytes. The CRC advances a full byte per cycle.
// The front end takes a word every cycle until the queue between the two ends is full;
// in_stall is queue-full alone. Asynchronous reset clears control state, sets the
// registers to their defaults and the CRC to all ones; there is no clearing pass.
module ax25_ui_frame_builder_top #(
	parameter int QueueDepth = ax25_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_of_input,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_end,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data
);

	ax25_pkg::addr_cfg_t addr_cfg_q;
	logic [7:0]          pay_limit_q;

	logic             push, pop, full, head_valid;
	ax25_pkg::entry_t push_entry, head;

	// Register file: always ready, drop writes to unknown indexes.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_cfg_q.dst_call  <= ax25_pkg::CALL_SPACES;
			addr_cfg_q.dest_ssid <= 4'd0;
			addr_cfg_q.src_call  <= ax25_pkg::CALL_SPACES;
			addr_cfg_q.src_ssid  <= 4'd0;
			pay_limit_q          <= ax25_pkg::MAXPAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (ax25_pkg::cfg_reg_t'(cfg_index))
				ax25_pkg::CFG_DEST_CALL: addr_cfg_q.dst_call  <= cfg_data;
				ax25_pkg::CFG_DEST_SSID: addr_cfg_q.dest_ssid <= cfg_data[3:0];
				ax25_pkg::CFG_SRC_CALL:  addr_cfg_q.src_call  <= cfg_data;
				ax25_pkg::CFG_SRC_SSID:  addr_cfg_q.src_ssid  <= cfg_data[3:0];
				ax25_pkg::CFG_MAX_PAY:   pay_limit_q          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Hold input while the queue is full.
	assign in_stall = full;

	ax25_fe u_fe (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.last_of_input (last_of_input),
		.pay_limit     (pay_limit_q),
		.push          (push),
		.push_entry    (push_entry)
	);

	ax25_q #(
		.Depth (QueueDepth)
	) u_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Advance the output register whenever it is empty or being taken.
	ax25_be u_be (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.addr_cfg   (addr_cfg_q),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.run_end    (run_end)
	);

endmodule
